/* sv/glet_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// glet_pkg: shared types and constants for the grey Laplacian edge unit
// Field widths, item and register codes, Q16 grey weights, grey conversion.
// ----------------------------------------------------------------------------
package glet_pkg;

  // Field widths of the channels
  localparam int COLOR_W = 8;
  localparam int GREY_W  = 8;
  localparam int CFG_DW  = 11;
  localparam int CFG_IW  = 2;
  localparam int THR_W   = 8;

  // Item codes on the op field
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IW-1:0] REG_FRAME_WIDTH    = 2'd0;
  localparam logic [CFG_IW-1:0] REG_FRAME_HEIGHT   = 2'd1;
  localparam logic [CFG_IW-1:0] REG_EDGE_THRESHOLD = 2'd2;

  // Register reset values
  localparam logic [CFG_DW-1:0] FRAME_WIDTH_RST  = 11'd1024;
  localparam logic [CFG_DW-1:0] FRAME_HEIGHT_RST = 11'd1024;
  localparam logic [THR_W-1:0]  THRESHOLD_RST    = 8'd128;

  // Q16 luma weights (0.299, 0.587, 0.114)
  localparam logic [15:0] GW_RED   = 16'd19595;
  localparam logic [15:0] GW_GREEN = 16'd38470;
  localparam logic [15:0] GW_BLUE  = 16'd7471;

  typedef logic [GREY_W-1:0] grey_t;

  // Weighted sum stays below 2^24; the grey value is its top byte.
  function automatic grey_t grey_of(input logic [COLOR_W-1:0] r,
                                    input logic [COLOR_W-1:0] g,
                                    input logic [COLOR_W-1:0] b);
    logic [23:0] acc;
    acc = 24'(GW_RED) * 24'(r) + 24'(GW_GREEN) * 24'(g) + 24'(GW_BLUE) * 24'(b);
    return acc[23:16];
  endfunction

endpackage : glet_pkg
`default_nettype wire

/* sv/glet_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// glet channel interfaces
// Pixel input, edge result and configuration write channels, valid/ready.
// ----------------------------------------------------------------------------
interface glet_pix_if;
  import glet_pkg::*;
  logic               valid;
  logic               ready;
  logic               op;
  logic [COLOR_W-1:0] red;
  logic [COLOR_W-1:0] green;
  logic [COLOR_W-1:0] blue;

  modport source (output valid, op, red, green, blue, input ready);
  modport sink   (input valid, op, red, green, blue, output ready);
endinterface : glet_pix_if

interface glet_res_if;
  logic valid;
  logic ready;
  logic edge_res;
  logic row_end;
  logic frame_end;

  modport source (output valid, edge_res, row_end, frame_end, input ready);
  modport sink   (input valid, edge_res, row_end, frame_end, output ready);
endinterface : glet_res_if

interface glet_cfg_if;
  import glet_pkg::*;
  logic              valid;
  logic              ready;
  logic [CFG_IW-1:0] index;
  logic [CFG_DW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface : glet_cfg_if
`default_nettype wire

/* sv/grey_laplace_edge_threshold_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// grey_laplace_edge_threshold_unit: grey 5-point Laplacian edge detector
// RGB raster stream in, one thresholded edge bit per pixel out.
// ----------------------------------------------------------------------------
// Pixels arrive in raster order for a frame of frame_width x frame_height.
// Each pixel is turned to grey with Q16 weights, and the Laplacian
// 4*centre - up - down - left - right (border replicated) is clamped to
// 0..255 and compared with edge_threshold; edge_res is 1 when it exceeds it.
// Results trail the input by frame_width + 1 items, so after the last pixel
// of a frame the source sends drain items (op = 1), one per pending result;
// a drain before the last pixel is dropped, and a pixel sent while the frame
// is flushing counts as a drain. row_end and frame_end mark the last result
// of a row and of the frame. The block takes one item per clock while out_ch
// does not stall it: the only state read per item is one entry of a 16-bit
// wide line memory (two grey lines side by side), read at acceptance and
// written back as the item leaves stage 1, with a bypass for back-to-back
// access to the same column (one-pixel-wide frames). A result is loaded into
// the output register as its item leaves stage 1, and out_ch is driven from
// that register; the output register lets the next item enter while a result
// waits. Writing frame_width or frame_height restarts the frame;
// edge_threshold takes effect at once. Configuration is taken on any cycle
// (cfg_ch.ready is tied high) and must be written while the block is idle.
// ----------------------------------------------------------------------------
module grey_laplace_edge_threshold_unit #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic       clk,
  input  logic       rst_n,
  glet_pix_if.sink   in_ch,
  glet_res_if.source out_ch,
  glet_cfg_if.sink   cfg_ch
);
  import glet_pkg::*;

  localparam int AW  = $clog2(MAX_WIDTH);       // column index
  localparam int WW  = $clog2(MAX_WIDTH + 1);   // frame width value
  localparam int HW  = $clog2(MAX_HEIGHT + 1);  // frame height value
  localparam int RWI = $clog2(MAX_HEIGHT + 2);  // input row, runs past h while flushing
  localparam int RWO = $clog2(MAX_HEIGHT);      // output row

  // Geometry is saturated into 1..MAX as it is written.
  function automatic logic [WW-1:0] clamp_w(input logic [CFG_DW-1:0] v);
    if (v == '0) return WW'(1);
    if (32'(v) > 32'(MAX_WIDTH)) return WW'(MAX_WIDTH);
    return WW'(v);
  endfunction

  function automatic logic [HW-1:0] clamp_h(input logic [CFG_DW-1:0] v);
    if (v == '0) return HW'(1);
    if (32'(v) > 32'(MAX_HEIGHT)) return HW'(MAX_HEIGHT);
    return HW'(v);
  endfunction

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [WW-1:0]    width_lim_r;
  logic [HW-1:0]    height_lim_r;
  logic [THR_W-1:0] thr_r;
  logic             cfg_wr;
  logic             geo_wr;

  assign cfg_ch.ready = 1'b1;
  assign cfg_wr = cfg_ch.valid && cfg_ch.ready;
  assign geo_wr = cfg_wr && (cfg_ch.index == REG_FRAME_WIDTH ||
                             cfg_ch.index == REG_FRAME_HEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_lim_r  <= clamp_w(FRAME_WIDTH_RST);
      height_lim_r <= clamp_h(FRAME_HEIGHT_RST);
      thr_r        <= THRESHOLD_RST;
    end else if (cfg_wr) begin
      case (cfg_ch.index)
        REG_FRAME_WIDTH:    width_lim_r  <= clamp_w(cfg_ch.data);
        REG_FRAME_HEIGHT:   height_lim_r <= clamp_h(cfg_ch.data);
        REG_EDGE_THRESHOLD: thr_r        <= cfg_ch.data[THR_W-1:0];
        default: ;  // index beyond the register list: no effect
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Acceptance: position tracking and per-item decisions
  // --------------------------------------------------------------------------
  logic [AW-1:0]  in_col_r,  in_col_nxt;
  logic [RWI-1:0] in_row_r,  in_row_nxt;
  logic [AW-1:0]  out_col_r, out_col_nxt;
  logic [RWO-1:0] out_row_r, out_row_nxt;

  logic  in_acc;
  logic  flushing;
  logic  launch;      // item does work (early drains are dropped)
  logic  emit;
  logic  in_col_last;
  logic  o_col_last;
  logic  o_row_last;
  logic  acc_fe;
  grey_t grey_in;

  // pipeline stage 1 (memory data valid)
  logic          s1_v_r;
  logic          s1_emit_r;
  logic [AW-1:0] s1_addr_r;
  grey_t         s1_grey_r;
  logic          s1_top_r, s1_bot_r, s1_lft_r, s1_rgt_r;
  logic          s1_fe_r;
  logic          s1_go;

  // output register
  logic out_v_r;
  logic out_edge_r, out_row_end_r, out_frame_end_r;
  logic out_free;

  assign out_free    = !out_v_r || out_ch.ready;
  assign s1_go       = s1_v_r && (!s1_emit_r || out_free);
  assign in_ch.ready = !s1_v_r || s1_go;
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_comb begin
    flushing    = in_row_r >= RWI'(height_lim_r);
    launch      = flushing || (in_ch.op == OP_PIXEL);
    // a pixel during flushing is treated as a drain: grey 0
    grey_in     = (flushing || in_ch.op == OP_DRAIN) ? '0
                : grey_of(in_ch.red, in_ch.green, in_ch.blue);
    emit        = (in_row_r >= RWI'(2)) || (in_row_r == RWI'(1) && in_col_r != '0);
    in_col_last = in_col_r == AW'(width_lim_r - WW'(1));
    o_col_last  = out_col_r == AW'(width_lim_r - WW'(1));
    o_row_last  = out_row_r == RWO'(height_lim_r - HW'(1));
    acc_fe      = emit && o_col_last && o_row_last;
  end

  always_comb begin
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (geo_wr) begin
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
    end else if (in_acc && launch) begin
      if (acc_fe) begin
        in_col_nxt  = '0;
        in_row_nxt  = '0;
        out_col_nxt = '0;
        out_row_nxt = '0;
      end else begin
        if (emit) begin
          if (o_col_last) begin
            out_col_nxt = '0;
            out_row_nxt = out_row_r + RWO'(1);
          end else begin
            out_col_nxt = out_col_r + AW'(1);
          end
        end
        if (in_col_last) begin
          in_col_nxt = '0;
          in_row_nxt = in_row_r + RWI'(1);
        end else begin
          in_col_nxt = in_col_r + AW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
    end
  end

  // stage 1 registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_v_r <= in_acc && launch;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_emit_r <= emit;
      s1_addr_r <= in_col_r;
      s1_grey_r <= grey_in;
      s1_top_r  <= out_row_r == '0;
      s1_bot_r  <= o_row_last;
      s1_lft_r  <= out_col_r == '0;
      s1_rgt_r  <= o_col_last;
      s1_fe_r   <= acc_fe;
    end
  end

  // --------------------------------------------------------------------------
  // Line memory: {line above centre, centre line} per column
  // --------------------------------------------------------------------------
  logic                     rd_en;
  logic [2*GREY_W-1:0]      ram_q;
  logic [2*GREY_W-1:0]      wr_data;
  logic [2*GREY_W-1:0]      fwd_data_r;
  logic                     fwd_sel_r;
  logic [2*GREY_W-1:0]      cur;
  grey_t                    cur_up, cur_mid;

  assign rd_en   = in_acc && launch;
  assign cur     = fwd_sel_r ? fwd_data_r : ram_q;
  assign cur_up  = cur[2*GREY_W-1:GREY_W];
  assign cur_mid = cur[GREY_W-1:0];
  assign wr_data = {cur_mid, s1_grey_r};  // shift the column up one line

  glet_line_ram #(
    .DEPTH (MAX_WIDTH),
    .DW    (2 * GREY_W)
  ) u_line_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (in_col_r),
    .rd_data (ram_q),
    .wr_en   (s1_go),
    .wr_addr (s1_addr_r),
    .wr_data (wr_data)
  );

  // bypass: a read landing on the column being written back this cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_sel_r <= 1'b0;
    end else if (rd_en) begin
      fwd_sel_r <= s1_go && (s1_addr_r == in_col_r);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_data_r <= wr_data;
    end
  end

  // --------------------------------------------------------------------------
  // Window and Laplacian
  // --------------------------------------------------------------------------
  grey_t win_up_r, win_mid_r, win_dn_r, win_left_r;
  grey_t nb_u, nb_d, nb_l, nb_r;
  logic signed [11:0] lap;
  grey_t lap_sat;
  logic edge_bit;

  always_comb begin
    nb_u     = s1_top_r ? win_mid_r : win_up_r;
    nb_d     = s1_bot_r ? win_mid_r : win_dn_r;
    nb_l     = s1_lft_r ? win_mid_r : win_left_r;
    nb_r     = s1_rgt_r ? win_mid_r : cur_mid;
    lap      = $signed({2'b00, win_mid_r, 2'b00})
             - $signed({4'b0000, nb_u}) - $signed({4'b0000, nb_d})
             - $signed({4'b0000, nb_l}) - $signed({4'b0000, nb_r});
    // clamp to 0..255 before the compare (255 never exceeds a 255 threshold)
    if (lap < 0) begin
      lap_sat = '0;
    end else if (lap > 12'sd255) begin
      lap_sat = 8'hFF;
    end else begin
      lap_sat = lap[GREY_W-1:0];
    end
    edge_bit = lap_sat > thr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_up_r   <= '0;
      win_mid_r  <= '0;
      win_dn_r   <= '0;
      win_left_r <= '0;
    end else if (geo_wr || (s1_go && s1_fe_r)) begin
      win_up_r   <= '0;
      win_mid_r  <= '0;
      win_dn_r   <= '0;
      win_left_r <= '0;
    end else if (s1_go) begin
      win_left_r <= win_mid_r;
      win_up_r   <= cur_up;
      win_mid_r  <= cur_mid;
      win_dn_r   <= s1_grey_r;
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_go && s1_emit_r) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_emit_r) begin
      out_edge_r      <= edge_bit;
      out_row_end_r   <= s1_rgt_r;
      out_frame_end_r <= s1_fe_r;
    end
  end

  assign out_ch.valid     = out_v_r;
  assign out_ch.edge_res  = out_edge_r;
  assign out_ch.row_end   = out_row_end_r;
  assign out_ch.frame_end = out_frame_end_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_emit_lands: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && s1_emit_r |=> out_v_r)
    else $error("retired result did not reach the output register");

  a_col_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    WW'(in_col_r) < width_lim_r)
    else $error("input column outside the frame");

  a_fe_on_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (!out_frame_end_r || out_row_end_r))
    else $error("frame end without row end");

  a_fe_restart: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && launch && acc_fe && !geo_wr |=> in_row_r == '0 && in_col_r == '0)
    else $error("positions not cleared after frame end");

endmodule : grey_laplace_edge_threshold_unit
`default_nettype wire

/* sv/glet_line_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// glet_line_ram: line buffer memory
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module glet_line_ram #(
  parameter int DEPTH = 1024,
  parameter int DW    = 16
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DW-1:0]            rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DW-1:0]            wr_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read-first: a same-address write in this cycle is not seen here
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule : glet_line_ram
`default_nettype wire
